// ===== src/mde_pkg.sv =====
// Shared types and constants for the MIDI event decoder.
// No dependencies; used by mde_pulse_timers, midi_event_decoder and the testbench.
`default_nettype none

package mde_pkg;

    localparam int PULSE_TIMER_BITS_DEF = 16;

    localparam int NUM_PULSES = 13;
    localparam int NUM_DIVS   = 5;
    localparam int NUM_SLOTS  = 4;

    // pulse_bits layout
    localparam int PB_START = 5;
    localparam int PB_STOP  = 6;
    localparam int PB_CONT  = 7;
    localparam int PB_PROG  = 8;
    localparam int PB_SLOT  = 9;

    // input item kinds
    typedef enum logic [1:0] {
        FUNC_MIDI      = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_SYS_RESET = 2'd2
    } func_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CHANNEL_SELECT  = 3'd0,
        CFG_INITIAL_RUNNING = 3'd1,
        CFG_PULSE_TICKS     = 3'd2,
        CFG_CC_NUMBER_A     = 3'd3,
        CFG_CC_NUMBER_B     = 3'd4,
        CFG_CC_NUMBER_C     = 3'd5,
        CFG_CC_NUMBER_D     = 3'd6
    } cfg_reg_t;

    // initial_running codes
    localparam logic [1:0] INIT_STOPPED    = 2'd0;
    localparam logic [1:0] INIT_RUNNING    = 2'd1;
    localparam logic [1:0] INIT_AUTO_START = 2'd2;

    // system realtime status bytes
    localparam logic [7:0] ST_CLOCK    = 8'hF8;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_CONTINUE = 8'hFB;
    localparam logic [7:0] ST_STOP     = 8'hFC;

    // channel voice message kinds (status high nibble)
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CC       = 4'hB;
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_BEND     = 4'hE;

    // controller numbers with a fixed meaning
    localparam logic [6:0] CC_BANK_MSB  = 7'd0;
    localparam logic [6:0] CC_MOD_WHEEL = 7'd1;
    localparam logic [6:0] CC_VOLUME    = 7'd7;
    localparam logic [6:0] CC_BANK_LSB  = 7'd32;
    localparam logic [6:0] CC_PORTA     = 7'd65;
    localparam logic [6:0] CC_SOFT      = 7'd67;

    localparam logic [4:0] PHASE_LAST = 5'd23;

    typedef struct packed {
        logic                  tick;
        logic [NUM_PULSES-1:0] fire;
    } pulse_ctrl_t;

    // which of the /1 /6 /8 /12 /24 dividers fire at this clock phase
    function automatic logic [NUM_DIVS-1:0] div_fire(input logic [4:0] phase);
        logic [NUM_DIVS-1:0] m;
        begin
            m[0] = 1'b1;
            m[1] = phase inside {5'd0, 5'd6, 5'd12, 5'd18};
            m[2] = phase inside {5'd0, 5'd8, 5'd16};
            m[3] = phase inside {5'd0, 5'd12};
            m[4] = (phase == 5'd0);
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/mde_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module mde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/mde_pulse_timers.sv =====
// Bank of trigger countdowns: loaded on fire, decremented per tick.
// Depends on mde_pkg.
`default_nettype none

module mde_pulse_timers #(
    parameter int TIMER_BITS = mde_pkg::PULSE_TIMER_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mde_pkg::pulse_ctrl_t          ctrl,
    input  wire logic [15:0]                   pulse_len,
    output logic [mde_pkg::NUM_PULSES-1:0]     active_next
);

    localparam longint unsigned MAX_LEN = (64'd1 << TIMER_BITS) - 64'd1;

    logic [TIMER_BITS-1:0] cnt_reg  [mde_pkg::NUM_PULSES];
    logic [TIMER_BITS-1:0] cnt_next [mde_pkg::NUM_PULSES];
    logic [63:0]           len64;
    logic [TIMER_BITS-1:0] load_val;

    // zero length counts as one tick, long lengths saturate
    always_comb
    begin
        len64    = (pulse_len == 16'd0) ? 64'd1 : 64'(pulse_len);
        load_val = (len64 > MAX_LEN) ? TIMER_BITS'(MAX_LEN) : TIMER_BITS'(len64);
    end

    always_comb
    begin
        for (int k = 0; k < mde_pkg::NUM_PULSES; k++)
        begin
            if (ctrl.fire[k])
            begin
                cnt_next[k] = load_val;
            end
            else if (ctrl.tick && (cnt_reg[k] != '0))
            begin
                cnt_next[k] = cnt_reg[k] - TIMER_BITS'(1);
            end
            else
            begin
                cnt_next[k] = cnt_reg[k];
            end
            active_next[k] = (cnt_next[k] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mde_pkg::NUM_PULSES; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < mde_pkg::NUM_PULSES; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/midi_event_decoder.sv =====
// MIDI event decoder: input register, then result register. Throughput one item
// per cycle while out_stall does not hold a full result register; each item is
// fully handled in the stage between the two registers, the velocity table read
// being issued on accept. Reset (rst_n, async, active low) restores configuration
// defaults and clears all state; the 128-entry velocity table is cleared at once
// through per-entry valid bits, so the block accepts items right after reset.
// Depends on mde_pkg, mde_ram, mde_pulse_timers.
`default_nettype none

module midi_event_decoder #(
    parameter int PULSE_TIMER_BITS = mde_pkg::PULSE_TIMER_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  status_byte,
    input  wire logic [6:0]  data_one,
    input  wire logic [6:0]  data_two,
    input  wire logic [6:0]  query_note,
    input  wire logic [1:0]  query_slot,
    // result items
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [12:0]      pulse_bits,
    output logic             running_flag,
    output logic             active_flag,
    output logic [6:0]       program_number,
    output logic [13:0]      bank_number,
    output logic [6:0]       mod_wheel,
    output logic [6:0]       main_volume,
    output logic signed [15:0] bend_value,
    output logic [1:0]       pedal_bits,
    output logic [6:0]       slot_value,
    output logic [6:0]       held_velocity
);

    localparam int NS = mde_pkg::NUM_SLOTS;

    // configuration
    logic [4:0]  chan_sel_reg;
    logic [1:0]  init_run_reg;
    logic [15:0] pulse_ticks_reg;
    logic [6:0]  cc_num_reg [NS];

    // input register
    logic        in_valid_reg;
    logic [1:0]  func_reg;
    logic [7:0]  status_reg;
    logic [6:0]  d1_reg;
    logic [6:0]  d2_reg;
    logic [6:0]  qnote_reg;
    logic [1:0]  qslot_reg;

    // decoder state
    logic [4:0]  phase_reg, phase_next;
    logic        running_reg, running_next;
    logic        started_reg, started_next;
    logic        seen_reg, seen_next;
    logic [6:0]  program_reg, program_next;
    logic [6:0]  bank_hi_reg, bank_hi_next;
    logic [6:0]  bank_lo_reg, bank_lo_next;
    logic [6:0]  mod_reg, mod_next;
    logic [6:0]  vol_reg, vol_next;
    logic [15:0] bend_reg, bend_next;
    logic [1:0]  pedal_reg, pedal_next;
    logic [6:0]  slot_reg  [NS];
    logic [6:0]  slot_next [NS];
    logic [127:0] vel_valid_reg;

    // velocity table access
    logic        ram_we;
    logic [6:0]  ram_wdata;
    logic [6:0]  ram_raddr;
    logic [6:0]  ram_rdata;
    logic        fwd_hit_reg;
    logic [6:0]  fwd_data_reg;
    logic [6:0]  stored_vel;
    logic [6:0]  held_next;

    // result register
    logic        out_valid_reg;
    logic [12:0] pulse_bits_reg;
    logic        running_out_reg;
    logic        active_out_reg;
    logic [6:0]  program_out_reg;
    logic [13:0] bank_out_reg;
    logic [6:0]  mod_out_reg;
    logic [6:0]  vol_out_reg;
    logic [15:0] bend_out_reg;
    logic [1:0]  pedal_out_reg;
    logic [6:0]  slot_out_reg;
    logic [6:0]  held_out_reg;

    // decode
    logic        advance;
    logic        in_take;
    logic        is_midi, is_tick, is_sys_reset;
    logic        is_rt;
    logic [3:0]  kind;
    logic [4:0]  chan_num;
    logic        chan_ok, chan_msg;
    logic        note_on, note_off, is_cc, is_prog, is_bend;
    logic        rt_clock, rt_start, rt_cont, rt_stop;
    logic        auto_start;
    logic        cc_down;
    logic [13:0] bend_raw;
    logic [14:0] bend_t;
    logic [1:0]  bend_corr;
    logic [12:0] pulse_active;

    mde_pkg::pulse_ctrl_t pctrl;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_sel_reg    <= '0;
            init_run_reg    <= mde_pkg::INIT_STOPPED;
            pulse_ticks_reg <= 16'd10;
            for (int k = 0; k < NS; k++)
            begin
                cc_num_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mde_pkg::CFG_CHANNEL_SELECT:  chan_sel_reg    <= cfg_data[4:0];
                mde_pkg::CFG_INITIAL_RUNNING: init_run_reg    <= cfg_data[1:0];
                mde_pkg::CFG_PULSE_TICKS:     pulse_ticks_reg <= cfg_data;
                mde_pkg::CFG_CC_NUMBER_A:     cc_num_reg[0]   <= cfg_data[6:0];
                mde_pkg::CFG_CC_NUMBER_B:     cc_num_reg[1]   <= cfg_data[6:0];
                mde_pkg::CFG_CC_NUMBER_C:     cc_num_reg[2]   <= cfg_data[6:0];
                mde_pkg::CFG_CC_NUMBER_D:     cc_num_reg[3]   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg   <= func;
            status_reg <= status_byte;
            d1_reg     <= data_one;
            d2_reg     <= data_two;
            qnote_reg  <= query_note;
            qslot_reg  <= query_slot;
        end
    end

    // message decode
    always_comb
    begin
        is_midi      = 1'b0;
        is_tick      = 1'b0;
        is_sys_reset = 1'b0;
        case (func_reg)
            mde_pkg::FUNC_MIDI:      is_midi      = 1'b1;
            mde_pkg::FUNC_TICK:      is_tick      = 1'b1;
            mde_pkg::FUNC_SYS_RESET: is_sys_reset = 1'b1;
            default: ;
        endcase

        is_rt    = (status_reg >= mde_pkg::ST_CLOCK);
        kind     = status_reg[7:4];
        chan_num = {1'b0, status_reg[3:0]} + 5'd1;
        chan_ok  = (chan_sel_reg == 5'd0) || (chan_sel_reg == chan_num);
        chan_msg = is_midi && !is_rt && chan_ok;

        note_on  = chan_msg && (kind == mde_pkg::KIND_NOTE_ON) && (d2_reg != 7'd0);
        note_off = chan_msg && !note_on
                   && ((kind == mde_pkg::KIND_NOTE_ON) || (kind == mde_pkg::KIND_NOTE_OFF));
        is_cc    = chan_msg && (kind == mde_pkg::KIND_CC);
        is_prog  = chan_msg && (kind == mde_pkg::KIND_PROGRAM);
        is_bend  = chan_msg && (kind == mde_pkg::KIND_BEND);

        rt_clock = is_midi && (status_reg == mde_pkg::ST_CLOCK);
        rt_start = is_midi && (status_reg == mde_pkg::ST_START);
        rt_cont  = is_midi && (status_reg == mde_pkg::ST_CONTINUE);
        rt_stop  = is_midi && (status_reg == mde_pkg::ST_STOP);

        auto_start = note_on && !started_reg && (init_run_reg == mde_pkg::INIT_AUTO_START);
        cc_down    = d2_reg[6];
    end

    // pitch bend: up is 4x + floor((3x + 4095) / 8191), since 32767 = 4*8191 + 3
    always_comb
    begin
        bend_raw = {d2_reg, d1_reg};
        bend_t   = 15'({bend_raw[12:0], 1'b0}) + 15'(bend_raw[12:0]) + 15'd4095;
        if (bend_t >= 15'd24573)
        begin
            bend_corr = 2'd3;
        end
        else if (bend_t >= 15'd16382)
        begin
            bend_corr = 2'd2;
        end
        else if (bend_t >= 15'd8191)
        begin
            bend_corr = 2'd1;
        end
        else
        begin
            bend_corr = 2'd0;
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        running_next = running_reg;
        started_next = started_reg;
        seen_next    = seen_reg || is_midi;
        program_next = program_reg;
        bank_hi_next = bank_hi_reg;
        bank_lo_next = bank_lo_reg;
        mod_next     = mod_reg;
        vol_next     = vol_reg;
        bend_next    = bend_reg;
        pedal_next   = pedal_reg;
        for (int k = 0; k < NS; k++)
        begin
            slot_next[k] = slot_reg[k];
        end
        pctrl.tick = advance && is_tick;
        pctrl.fire = '0;

        if (rt_clock)
        begin
            pctrl.fire[mde_pkg::NUM_DIVS-1:0] = mde_pkg::div_fire(phase_reg);
            phase_next = (phase_reg == mde_pkg::PHASE_LAST) ? 5'd0 : phase_reg + 5'd1;
        end
        if (rt_start)
        begin
            running_next = 1'b1;
            started_next = 1'b1;
            phase_next   = 5'd0;
        end
        if (rt_cont)
        begin
            running_next = 1'b1;
            started_next = 1'b1;
        end
        if (rt_stop)
        begin
            running_next = 1'b0;
        end
        if (auto_start)
        begin
            running_next = 1'b1;
            started_next = 1'b1;
        end
        pctrl.fire[mde_pkg::PB_START] = rt_start || auto_start;
        pctrl.fire[mde_pkg::PB_CONT]  = rt_cont;
        pctrl.fire[mde_pkg::PB_STOP]  = rt_stop;
        pctrl.fire[mde_pkg::PB_PROG]  = is_prog;

        if (is_cc)
        begin
            if (d1_reg == mde_pkg::CC_PORTA)     pedal_next[0] = cc_down;
            if (d1_reg == mde_pkg::CC_SOFT)      pedal_next[1] = cc_down;
            if (d1_reg == mde_pkg::CC_BANK_MSB)  bank_hi_next  = d2_reg;
            if (d1_reg == mde_pkg::CC_BANK_LSB)  bank_lo_next  = d2_reg;
            if (d1_reg == mde_pkg::CC_MOD_WHEEL) mod_next      = d2_reg;
            if (d1_reg == mde_pkg::CC_VOLUME)    vol_next      = d2_reg;
            for (int k = 0; k < NS; k++)
            begin
                if (cc_num_reg[k] == d1_reg)
                begin
                    slot_next[k] = d2_reg;
                    pctrl.fire[mde_pkg::PB_SLOT + k] = 1'b1;
                end
            end
        end
        if (is_prog)
        begin
            program_next = d1_reg;
        end
        if (is_bend)
        begin
            if (bend_raw[13])
            begin
                bend_next = {1'b0, bend_raw[12:0], 2'b00} + 16'(bend_corr);
            end
            else
            begin
                bend_next = {1'b1, bend_raw[12:0], 2'b00};
            end
        end

        if (is_sys_reset)
        begin
            phase_next   = 5'd0;
            running_next = (init_run_reg == mde_pkg::INIT_RUNNING);
            started_next = (init_run_reg == mde_pkg::INIT_RUNNING);
            mod_next     = '0;
            vol_next     = '0;
            bend_next    = '0;
            pedal_next   = '0;
            for (int k = 0; k < NS; k++)
            begin
                slot_next[k] = '0;
            end
        end

        if (!advance)
        begin
            pctrl.fire = '0;
        end
    end

    // velocity table: RAM data plus per-entry valid bits
    assign ram_we    = advance && (note_on || note_off);
    assign ram_wdata = note_on ? d2_reg : 7'd0;
    assign ram_raddr = in_take ? query_note : qnote_reg;

    mde_ram #(
        .WIDTH (7),
        .DEPTH (128)
    ) u_vel_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (d1_reg),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // a write landing in the same cycle as the read misses the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= ram_we && (d1_reg == ram_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
    end

    always_comb
    begin
        if (!vel_valid_reg[qnote_reg])
        begin
            stored_vel = 7'd0;
        end
        else if (fwd_hit_reg)
        begin
            stored_vel = fwd_data_reg;
        end
        else
        begin
            stored_vel = ram_rdata;
        end

        if (is_sys_reset)
        begin
            held_next = 7'd0;
        end
        else if ((note_on || note_off) && (d1_reg == qnote_reg))
        begin
            held_next = ram_wdata;
        end
        else
        begin
            held_next = stored_vel;
        end
    end

    mde_pulse_timers #(
        .TIMER_BITS (PULSE_TIMER_BITS)
    ) u_timers (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (pctrl),
        .pulse_len   (pulse_ticks_reg),
        .active_next (pulse_active)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            running_reg   <= 1'b0;
            started_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            program_reg   <= '0;
            bank_hi_reg   <= '0;
            bank_lo_reg   <= '0;
            mod_reg       <= '0;
            vol_reg       <= '0;
            bend_reg      <= '0;
            pedal_reg     <= '0;
            vel_valid_reg <= '0;
            for (int k = 0; k < NS; k++)
            begin
                slot_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            running_reg <= running_next;
            started_reg <= started_next;
            seen_reg    <= seen_next;
            program_reg <= program_next;
            bank_hi_reg <= bank_hi_next;
            bank_lo_reg <= bank_lo_next;
            mod_reg     <= mod_next;
            vol_reg     <= vol_next;
            bend_reg    <= bend_next;
            pedal_reg   <= pedal_next;
            for (int k = 0; k < NS; k++)
            begin
                slot_reg[k] <= slot_next[k];
            end
            if (is_sys_reset)
            begin
                vel_valid_reg <= '0;
            end
            else if (note_on || note_off)
            begin
                vel_valid_reg[d1_reg] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pulse_bits_reg  <= pulse_active;
            running_out_reg <= running_next;
            active_out_reg  <= seen_next;
            program_out_reg <= program_next;
            bank_out_reg    <= {bank_hi_next, bank_lo_next};
            mod_out_reg     <= mod_next;
            vol_out_reg     <= vol_next;
            bend_out_reg    <= bend_next;
            pedal_out_reg   <= pedal_next;
            slot_out_reg    <= slot_next[qslot_reg];
            held_out_reg    <= held_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pulse_bits     = pulse_bits_reg;
    assign running_flag   = running_out_reg;
    assign active_flag    = active_out_reg;
    assign program_number = program_out_reg;
    assign bank_number    = bank_out_reg;
    assign mod_wheel      = mod_out_reg;
    assign main_volume    = vol_out_reg;
    assign bend_value     = bend_out_reg;
    assign pedal_bits     = pedal_out_reg;
    assign slot_value     = slot_out_reg;
    assign held_velocity  = held_out_reg;

endmodule

`default_nettype wire

// ===== src/mde_checker.sv =====
// Port-level checks for midi_event_decoder, bound to the top level.
// Depends on midi_event_decoder.
`default_nettype none

module mde_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [12:0] pulse_bits,
    input wire logic        active_flag,
    input wire logic [15:0] bend_value,
    input wire logic [6:0]  held_velocity
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable(pulse_bits) && $stable(bend_value) && $stable(held_velocity))
        else $error("result changed while stalled");

    // input side only backs up when the result side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result register");

    // every accepted transaction is followed by out_valid, through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 out_valid)
        else $error("accepted item produced no result");

    // activity never clears once seen
    a_active_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && active_flag |=> active_flag)
        else $error("active flag dropped");

endmodule

bind midi_event_decoder mde_checker u_mde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pulse_bits    (pulse_bits),
    .active_flag   (active_flag),
    .bend_value    (bend_value),
    .held_velocity (held_velocity)
);

`default_nettype wire

// ===== sim/midi_event_decoder_test.sv =====
// Self-checking testbench for midi_event_decoder: a directed table, then random
// phases under several register settings, all checked against an in-bench model.
// Depends on mde_pkg and the decoder RTL under src.

module midi_event_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mde_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED        = 2'd3;
    localparam logic [7:0]  ST_UNDEF_RT        = 8'hFD;
    localparam logic [3:0]  KIND_POLY_PRESSURE = 4'hA;
    localparam logic [15:0] RESET_PULSE_TICKS  = 16'd10;
    localparam logic [15:0] MAX_PULSE_TICKS    = 16'hFFFF;
    localparam logic [6:0]  NOTE_LO            = 7'd60;
    localparam logic [6:0]  NOTE_HI            = 7'd67;
    localparam logic [4:0][4:0] CLOCK_DIVS     = {5'd24, 5'd12, 5'd8, 5'd6, 5'd1};

    localparam int NUM_FIELDS   = 11;
    localparam int SCRIPT_LEN   = 25;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 75;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        logic [1:0] func;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [6:0] qn;
        logic [1:0] qs;
    } midi_item_t;

    typedef struct {
        logic [12:0]        pulse_bits;
        logic               running_flag;
        logic               active_flag;
        logic [6:0]         program_number;
        logic [13:0]        bank_number;
        logic [6:0]         mod_wheel;
        logic [6:0]         main_volume;
        logic signed [15:0] bend_value;
        logic [1:0]         pedal_bits;
        logic [6:0]         slot_value;
        logic [6:0]         held_velocity;
    } decode_result_t;

    // pinned rows carry a typed-in bend and held velocity
    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         status;
        logic [6:0]         d1;
        logic [6:0]         d2;
        logic [6:0]         qn;
        logic [1:0]         qs;
        logic               pinned;
        logic signed [15:0] bend;
        logic [6:0]         velocity;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{FUNC_TICK, 8'h00, 7'd0, 7'd0, 7'd0, 2'd0, 1'b1, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_NOTE_ON, 4'h0}, 7'd0, 7'd127, 7'd0, 2'd0, 1'b1, 16'sd0, 7'd127},
        '{FUNC_MIDI, {KIND_NOTE_ON, 4'hF}, 7'd127, 7'd1, 7'd127, 2'd0, 1'b1, 16'sd0, 7'd1},
        '{FUNC_MIDI, {KIND_NOTE_ON, 4'h3}, 7'd127, 7'd0, 7'd127, 2'd0, 1'b1, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd64, 7'd0, 2'd0, 1'b1, 16'sd0, 7'd0},
        '{FUNC_TICK, 8'hFF, 7'd127, 7'd127, 7'd0, 2'd3, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_BEND, 4'h0}, 7'd0, 7'd0, 7'd5, 2'd0, 1'b1, 16'sh8000, 7'd0},
        '{FUNC_MIDI, {KIND_BEND, 4'h5}, 7'd127, 7'd127, 7'd5, 2'd0, 1'b1, 16'sh7FFF, 7'd0},
        '{FUNC_MIDI, {KIND_BEND, 4'h0}, 7'd0, 7'd64, 7'd5, 2'd0, 1'b1, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_BEND, 4'h0}, 7'd127, 7'd63, 7'd5, 2'd0, 1'b1, -16'sd4, 7'd0},
        '{FUNC_MIDI, {KIND_BEND, 4'h0}, 7'd1, 7'd64, 7'd5, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_CC, 4'h0}, CC_BANK_MSB, 7'd127, 7'd0, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_CC, 4'h0}, CC_BANK_LSB, 7'd5, 7'd0, 2'd1, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_CC, 4'h2}, CC_MOD_WHEEL, 7'd100, 7'd0, 2'd2, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_CC, 4'h0}, CC_VOLUME, 7'd127, 7'd0, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_CC, 4'h0}, CC_PORTA, 7'd64, 7'd0, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_CC, 4'h0}, CC_SOFT, 7'd127, 7'd0, 2'd3, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, {KIND_PROGRAM, 4'h9}, 7'd127, 7'd0, 7'd0, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, ST_CLOCK, 7'd0, 7'd0, 7'd0, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, ST_STOP, 7'd0, 7'd0, 7'd0, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, ST_CONTINUE, 7'd0, 7'd0, 7'd0, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, ST_START, 7'd0, 7'd0, 7'd0, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_MIDI, ST_UNDEF_RT, 7'd3, 7'd4, 7'd0, 2'd0, 1'b0, 16'sd0, 7'd0},
        '{FUNC_UNUSED, {KIND_POLY_PRESSURE, 4'h5}, 7'd9, 7'd9, 7'd0, 2'd1, 1'b0, 16'sd0, 7'd0},
        '{FUNC_SYS_RESET, 8'h00, 7'd0, 7'd0, 7'd0, 2'd0, 1'b1, 16'sd0, 7'd0}
    };

    string field_names [NUM_FIELDS] = '{"pulse_bits", "running_flag", "active_flag",
        "program_number", "bank_number", "mod_wheel", "main_volume", "bend_value",
        "pedal_bits", "slot_value", "held_velocity"};

    // DUT ports
    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [15:0]       cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        func;
    logic [7:0]        status_byte;
    logic [6:0]        data_one;
    logic [6:0]        data_two;
    logic [6:0]        query_note;
    logic [1:0]        query_slot;
    logic              out_valid;
    logic              out_stall;
    logic [12:0]       pulse_bits;
    logic              running_flag;
    logic              active_flag;
    logic [6:0]        program_number;
    logic [13:0]       bank_number;
    logic [6:0]        mod_wheel;
    logic [6:0]        main_volume;
    logic signed [15:0] bend_value;
    logic [1:0]        pedal_bits;
    logic [6:0]        slot_value;
    logic [6:0]        held_velocity;

    // model configuration
    logic [4:0]  sel_channel;
    logic [1:0]  run_mode;
    logic [15:0] pulse_len;
    logic [6:0]  slot_cc [NUM_SLOTS];

    // model state
    logic [6:0]  velocity_of [128];
    logic [4:0]  beat_phase;
    logic        is_running;
    logic        is_started;
    logic        any_activity;
    logic [15:0] countdown [NUM_PULSES];
    logic [6:0]  prog_reg;
    logic [6:0]  bank_msb;
    logic [6:0]  bank_lsb;
    logic [6:0]  mod_reg;
    logic [6:0]  vol_reg;
    logic [15:0] bend_reg;
    logic [1:0]  pedals;
    logic [6:0]  slot_val [NUM_SLOTS];

    decode_result_t awaited_outputs [$];
    int unsigned    errors = 0;
    bit             steady = 1'b0;
    bit             hold_pending = 1'b0;

    midi_event_decoder dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void fire_pulse(int idx);
        countdown[idx] = (pulse_len == 16'd0) ? 16'd1 : pulse_len;
    endfunction

    // system reset item: program, bank, activity and live pulses survive
    function automatic void clear_voice_state();
        foreach (velocity_of[n]) velocity_of[n] = '0;
        foreach (slot_val[k]) slot_val[k] = '0;
        mod_reg    = '0;
        vol_reg    = '0;
        bend_reg   = '0;
        pedals     = '0;
        beat_phase = '0;
        is_running = (run_mode == INIT_RUNNING);
        is_started = (run_mode == INIT_RUNNING);
    endfunction

    function automatic void control_change(logic [6:0] num, logic [6:0] val);
        if (num == CC_PORTA) pedals[0] = val[6];
        if (num == CC_SOFT) pedals[1] = val[6];
        if (num == CC_BANK_MSB) bank_msb = val;
        if (num == CC_BANK_LSB) bank_lsb = val;
        if (num == CC_MOD_WHEEL) mod_reg = val;
        if (num == CC_VOLUME) vol_reg = val;
        for (int k = 0; k < NUM_SLOTS; k++)
            if (slot_cc[k] == num)
            begin
                slot_val[k] = val;
                fire_pulse(PB_SLOT + k);
            end
    endfunction

    function automatic decode_result_t decode_event(midi_item_t it);
        decode_result_t r;
        logic [4:0]  chan;
        logic [13:0] bend_in;
        int unsigned scaled;
        chan = {1'b0, it.status[3:0]} + 5'd1;
        if (it.func == FUNC_MIDI)
        begin
            any_activity = 1'b1;
            if (it.status >= ST_CLOCK)
            begin
                case (it.status)
                    ST_CLOCK:
                    begin
                        for (int d = 0; d < NUM_DIVS; d++)
                            if (beat_phase % CLOCK_DIVS[d] == 0) fire_pulse(d);
                        beat_phase = (beat_phase == PHASE_LAST) ? 5'd0 : beat_phase + 5'd1;
                    end
                    ST_START:
                    begin
                        is_running = 1'b1;
                        is_started = 1'b1;
                        fire_pulse(PB_START);
                        beat_phase = '0;
                    end
                    ST_CONTINUE:
                    begin
                        is_running = 1'b1;
                        is_started = 1'b1;
                        fire_pulse(PB_CONT);
                    end
                    ST_STOP:
                    begin
                        is_running = 1'b0;
                        fire_pulse(PB_STOP);
                    end
                    default: ;
                endcase
            end
            else if (sel_channel == 5'd0 || sel_channel == chan)
            begin
                case (it.status[7:4])
                    KIND_NOTE_ON:
                    begin
                        velocity_of[it.d1] = it.d2;
                        // auto-start keeps the clock phase
                        if (it.d2 != 7'd0 && !is_started && run_mode == INIT_AUTO_START)
                        begin
                            is_running = 1'b1;
                            is_started = 1'b1;
                            fire_pulse(PB_START);
                        end
                    end
                    KIND_NOTE_OFF: velocity_of[it.d1] = '0;
                    KIND_CC: control_change(it.d1, it.d2);
                    KIND_PROGRAM:
                    begin
                        prog_reg = it.d1;
                        fire_pulse(PB_PROG);
                    end
                    KIND_BEND:
                    begin
                        bend_in = {it.d2, it.d1};
                        if (bend_in >= 14'd8192)
                        begin
                            scaled = (int'(bend_in) - 8192) * 32767 + 4095;
                            bend_reg = 16'(scaled / 8191);
                        end
                        else
                            bend_reg = 16'(32'h10000 - (8192 - int'(bend_in)) * 4);
                    end
                    default: ;
                endcase
            end
        end
        else if (it.func == FUNC_TICK)
        begin
            for (int k = 0; k < NUM_PULSES; k++)
                if (countdown[k] != 16'd0) countdown[k] = countdown[k] - 16'd1;
        end
        else if (it.func == FUNC_SYS_RESET)
            clear_voice_state();

        for (int k = 0; k < NUM_PULSES; k++)
            r.pulse_bits[k] = (countdown[k] != 16'd0);
        r.running_flag   = is_running;
        r.active_flag    = any_activity;
        r.program_number = prog_reg;
        r.bank_number    = {bank_msb, bank_lsb};
        r.mod_wheel      = mod_reg;
        r.main_volume    = vol_reg;
        r.bend_value     = bend_reg;
        r.pedal_bits     = pedals;
        r.slot_value     = slot_val[it.qs];
        r.held_velocity  = velocity_of[it.qn];
        return r;
    endfunction

    function automatic int field_of(decode_result_t r, int k);
        case (k)
            0:       return r.pulse_bits;
            1:       return r.running_flag;
            2:       return r.active_flag;
            3:       return r.program_number;
            4:       return r.bank_number;
            5:       return r.mod_wheel;
            6:       return r.main_volume;
            7:       return r.bend_value;
            8:       return r.pedal_bits;
            9:       return r.slot_value;
            default: return r.held_velocity;
        endcase
    endfunction

    // mostly controllers that do something under the current settings
    function automatic logic [6:0] controller_pick();
        case ($urandom_range(0, 3))
            0: return slot_cc[$urandom_range(0, NUM_SLOTS - 1)];
            1:
            begin
                case ($urandom_range(0, 5))
                    0:       return CC_BANK_MSB;
                    1:       return CC_BANK_LSB;
                    2:       return CC_MOD_WHEEL;
                    3:       return CC_VOLUME;
                    4:       return CC_PORTA;
                    default: return CC_SOFT;
                endcase
            end
            default: return 7'($urandom);
        endcase
    endfunction

    function automatic midi_item_t random_item();
        midi_item_t  it;
        int unsigned pick;
        logic [3:0]  chan;
        it.func   = FUNC_MIDI;
        it.status = 8'($urandom);
        it.d1     = 7'($urandom);
        it.d2     = 7'($urandom);
        it.qn     = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(NOTE_LO, NOTE_HI))
                                                : 7'($urandom);
        it.qs     = 2'($urandom);
        if (sel_channel >= 5'd1 && sel_channel <= 5'd16 && $urandom_range(0, 3) != 0)
            chan = 4'(sel_channel - 5'd1);
        else
            chan = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25)
            it.func = FUNC_TICK;
        else if (pick < 45)
            it.status = ST_CLOCK;
        else if (pick < 50)
        begin
            case ($urandom_range(0, 2))
                0:       it.status = ST_START;
                1:       it.status = ST_CONTINUE;
                default: it.status = ST_STOP;
            endcase
        end
        else if (pick < 67)
        begin
            it.status = {(pick < 62) ? KIND_NOTE_ON : KIND_NOTE_OFF, chan};
            if ($urandom_range(0, 3) != 0) it.d1 = 7'($urandom_range(NOTE_LO, NOTE_HI));
            if ($urandom_range(0, 4) == 0) it.d2 = '0;
        end
        else if (pick < 80)
        begin
            it.status = {KIND_CC, chan};
            it.d1     = controller_pick();
        end
        else if (pick < 85)
            it.status = {KIND_PROGRAM, chan};
        else if (pick < 91)
            it.status = {KIND_BEND, chan};
        else if (pick < 93)
            it.func = FUNC_SYS_RESET;
        else if (pick < 94)
            it.func = FUNC_UNUSED;
        // otherwise a message with an arbitrary status byte
        return it;
    endfunction

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_CHANNEL_SELECT:  sel_channel = value[4:0];
            CFG_INITIAL_RUNNING: run_mode    = value[1:0];
            CFG_PULSE_TICKS:     pulse_len   = value;
            CFG_CC_NUMBER_A:     slot_cc[0]  = value[6:0];
            CFG_CC_NUMBER_B:     slot_cc[1]  = value[6:0];
            CFG_CC_NUMBER_C:     slot_cc[2]  = value[6:0];
            default:             slot_cc[3]  = value[6:0];
        endcase
    endtask

    task automatic apply_settings(logic [4:0] ch, logic [1:0] mode, logic [15:0] len,
                                  logic [6:0] a, logic [6:0] b, logic [6:0] c,
                                  logic [6:0] d);
        write_reg(CFG_CHANNEL_SELECT, 16'(ch));
        write_reg(CFG_INITIAL_RUNNING, 16'(mode));
        write_reg(CFG_PULSE_TICKS, len);
        write_reg(CFG_CC_NUMBER_A, 16'(a));
        write_reg(CFG_CC_NUMBER_B, 16'(b));
        write_reg(CFG_CC_NUMBER_C, 16'(c));
        write_reg(CFG_CC_NUMBER_D, 16'(d));
        cfg_valid <= 1'b0;
    endtask

    // leaves in_valid high so back-to-back items keep it asserted
    task automatic offer_item(midi_item_t it, logic pinned, logic signed [15:0] pin_bend,
                              logic [6:0] pin_vel);
        int unsigned    gap;
        decode_result_t want;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= it.func;
        status_byte <= it.status;
        data_one    <= it.d1;
        data_two    <= it.d2;
        query_note  <= it.qn;
        query_slot  <= it.qs;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        want = decode_event(it);
        if (pinned)
        begin
            want.bend_value    = pin_bend;
            want.held_velocity = pin_vel;
        end
        awaited_outputs.push_back(want);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin : result_side
        decode_result_t got;
        decode_result_t want;
        int unsigned    wait_left;
        int unsigned    hold_left;
        wait_left = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.pulse_bits     = pulse_bits;
                got.running_flag   = running_flag;
                got.active_flag    = active_flag;
                got.program_number = program_number;
                got.bank_number    = bank_number;
                got.mod_wheel      = mod_wheel;
                got.main_volume    = main_volume;
                got.bend_value     = bend_value;
                got.pedal_bits     = pedal_bits;
                got.slot_value     = slot_value;
                got.held_velocity  = held_velocity;
                if (awaited_outputs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction, pulse_bits %0d",
                             $realtime, got.pulse_bits);
                end
                else
                begin
                    want = awaited_outputs.pop_front();
                    for (int k = 0; k < NUM_FIELDS; k++)
                        if (field_of(got, k) != field_of(want, k))
                        begin
                            errors++;
                            $display("%0t: %s expected %0d actual %0d", $realtime,
                                     field_names[k], field_of(want, k), field_of(got, k));
                        end
                end
                wait_left = steady ? 0 : $urandom_range(0, 4);
            end
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (wait_left != 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        midi_item_t  it;
        script_row_t row;
        logic [4:0]  ch;
        logic [1:0]  mode;
        logic [15:0] len;
        logic [6:0]  cc [NUM_SLOTS];

        sel_channel  = '0;
        run_mode     = INIT_STOPPED;
        pulse_len    = RESET_PULSE_TICKS;
        foreach (slot_cc[k]) slot_cc[k] = '0;
        any_activity = 1'b0;
        foreach (countdown[k]) countdown[k] = '0;
        prog_reg     = '0;
        bank_msb     = '0;
        bank_lsb     = '0;
        clear_voice_state();

        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_CHANNEL_SELECT;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        func        <= FUNC_MIDI;
        status_byte <= '0;
        data_one    <= '0;
        data_two    <= '0;
        query_note  <= '0;
        query_slot  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // auto-start armed, zero pulse length (acts as one tick)
        apply_settings(5'd0, INIT_AUTO_START, 16'd0, CC_BANK_MSB, 7'd127, CC_MOD_WHEEL,
                       CC_SOFT);
        for (int n = 0; n < SCRIPT_LEN; n++)
        begin
            row = SCRIPT[n];
            it  = '{row.func, row.status, row.d1, row.d2, row.qn, row.qs};
            offer_item(it, row.pinned, row.bend, row.velocity);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            foreach (cc[k]) cc[k] = controller_pick();
            ch   = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(1, 16));
            mode = 2'($urandom_range(0, 2));
            len  = 16'($urandom_range(1, 12));
            case (p)
                0: begin ch = 5'd0;  mode = INIT_RUNNING; len = 16'd1;   end
                1: begin ch = 5'd16; mode = INIT_STOPPED; len = MAX_PULSE_TICKS; end
                2: begin ch = 5'd17; mode = INIT_AUTO_START; len = 16'd3; end
                3: begin ch = 5'd1;  mode = INIT_RUNNING;                 end
                4: begin ch = 5'd31; mode = INIT_STOPPED; len = 16'd2;    end
                5:
                begin
                    mode = INIT_AUTO_START;
                    foreach (cc[k]) cc[k] = cc[0];
                end
                6: begin ch = 5'd0;  mode = INIT_AUTO_START;              end
                default: ;
            endcase
            apply_settings(ch, mode, len, cc[0], cc[1], cc[2], cc[3]);
            steady = (p == 3 || p == 6);
            if (p == 3) hold_pending = 1'b1;
            // new initial_running only lands on a system reset
            it = random_item();
            it.func = FUNC_SYS_RESET;
            offer_item(it, 1'b0, '0, '0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_item(random_item(), 1'b0, '0, '0);
        end

        steady = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== midi_event_decoder.f =====
src/mde_pkg.sv
src/mde_ram.sv
src/mde_pulse_timers.sv
src/midi_event_decoder.sv
src/mde_checker.sv
sim/midi_event_decoder_test.sv
